[hw/rtl/bee_pkg.sv]
// shared types and constants for the byte escape encoder
package bee_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_ESCAPE_FLAGS = 3'd0;
	localparam logic [2:0] CFG_OUT_LIMIT    = 3'd1;
	localparam logic [2:0] CFG_SET_ENABLE   = 3'd2;
	localparam logic [2:0] CFG_SET_MASK_A   = 3'd3;
	localparam logic [2:0] CFG_SET_MASK_B   = 3'd4;
	localparam logic [2:0] CFG_SET_MASK_C   = 3'd5;
	localparam logic [2:0] CFG_SET_MASK_D   = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int FLAGS_W     = 6;
	localparam int LIMIT_W     = 32;
	localparam int LENGTH_W    = 32;

	// escape_flags bit positions
	localparam int FLAG_SPACE   = 0;
	localparam int FLAG_SPECIAL = 1;
	localparam int FLAG_NULL    = 2;
	localparam int FLAG_OCTAL   = 3;
	localparam int FLAG_SKIP    = 4;
	localparam int FLAG_HEX     = 5;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	// queue between classifier and emitter (depth a power of two)
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// one classified item: up to four characters and the index of the last one
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            str_end;
	} seq_t;

endpackage

[hw/rtl/bee_front.sv]
// classifier: turns one source byte into its escape sequence
module bee_front (
	input  logic [7:0]                     in_byte,
	input  logic                           string_end,
	input  logic [bee_pkg::FLAGS_W-1:0]    escape_flags,
	input  logic                           set_enable,
	input  logic [255:0]                   set_mask,
	output bee_pkg::seq_t                  seq
);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_X     = 8'h78;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] d;
		if (v < 4'd10) d = CH_ZERO + {4'd0, v};
		else d = CH_LOW_A + {4'd0, v} - 8'd10;
		return d;
	endfunction

	logic       printable;
	logic       member;
	logic       may_escape;
	logic [7:0] ws_code;
	logic [7:0] sp_code;

	assign printable = (in_byte >= 8'h20 && in_byte <= 8'h7E) || in_byte >= 8'hA0;
	assign member    = (in_byte == 8'h00) || set_mask[in_byte];
	assign may_escape = !(escape_flags[bee_pkg::FLAG_SKIP] && printable)
		&& !(set_enable && !member);

	always_comb begin
		case (in_byte)
			8'h0A:   ws_code = 8'h6E;
			8'h0D:   ws_code = 8'h72;
			8'h09:   ws_code = 8'h74;
			8'h0B:   ws_code = 8'h76;
			8'h0C:   ws_code = 8'h66;
			default: ws_code = 8'h00;
		endcase
		case (in_byte)
			8'h5C:   sp_code = bee_pkg::CH_BACKSLASH;
			8'h07:   sp_code = 8'h61;
			8'h1B:   sp_code = 8'h65;
			default: sp_code = 8'h00;
		endcase
	end

	always_comb begin
		seq.chars    = '0;
		seq.chars[0] = in_byte;
		seq.last_idx = 2'd0;
		seq.str_end  = string_end;
		if (may_escape) begin
			if (escape_flags[bee_pkg::FLAG_SPACE] && ws_code != 8'h00) begin
				seq.chars[0] = bee_pkg::CH_BACKSLASH;
				seq.chars[1] = ws_code;
				seq.last_idx = 2'd1;
			end else if (escape_flags[bee_pkg::FLAG_SPECIAL] && sp_code != 8'h00) begin
				seq.chars[0] = bee_pkg::CH_BACKSLASH;
				seq.chars[1] = sp_code;
				seq.last_idx = 2'd1;
			end else if (escape_flags[bee_pkg::FLAG_NULL] && in_byte == 8'h00) begin
				seq.chars[0] = bee_pkg::CH_BACKSLASH;
				seq.chars[1] = CH_ZERO;
				seq.last_idx = 2'd1;
			end else if (escape_flags[bee_pkg::FLAG_OCTAL]) begin
				seq.chars[0] = bee_pkg::CH_BACKSLASH;
				seq.chars[1] = CH_ZERO + {5'd0, 1'b0, in_byte[7:6]};
				seq.chars[2] = CH_ZERO + {5'd0, in_byte[5:3]};
				seq.chars[3] = CH_ZERO + {5'd0, in_byte[2:0]};
				seq.last_idx = 2'd3;
			end else if (escape_flags[bee_pkg::FLAG_HEX]) begin
				seq.chars[0] = bee_pkg::CH_BACKSLASH;
				seq.chars[1] = CH_X;
				seq.chars[2] = hex_digit(in_byte[7:4]);
				seq.chars[3] = hex_digit(in_byte[3:0]);
				seq.last_idx = 2'd3;
			end
		end
	end

endmodule

[hw/rtl/bee_queue.sv]
// short queue of classified items between classifier and emitter
module bee_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bee_pkg::seq_t push_seq,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output bee_pkg::seq_t head_seq
);

	bee_pkg::seq_t                   entries_q [bee_pkg::Q_DEPTH];
	logic [bee_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [bee_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [bee_pkg::Q_CNT_W-1:0]     count_q;

	assign full      = count_q == bee_pkg::Q_CNT_W'(bee_pkg::Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head_seq  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bee_pkg::Q_CNT_W'(bee_pkg::Q_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

[hw/rtl/bee_back.sv]
// emitter: one character per cycle while the output is not stalled, position tracking and output register
module bee_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  bee_pkg::seq_t                 head_seq,
	output logic                          pop,
	input  logic [bee_pkg::LIMIT_W-1:0]   out_limit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          stored,
	output logic                          run_last,
	output logic [bee_pkg::LENGTH_W-1:0]  total_length
);

	localparam int CMP_W = (COUNT_BITS > bee_pkg::LIMIT_W) ? COUNT_BITS : bee_pkg::LIMIT_W;

	logic [1:0]                   k_q;
	logic [COUNT_BITS-1:0]        pos_q;
	logic                         out_valid_q;
	logic [7:0]                   out_char_q;
	logic                         stored_q;
	logic                         run_last_q;
	logic [bee_pkg::LENGTH_W-1:0] total_q;

	logic                  advance;
	logic                  is_last;
	logic [COUNT_BITS-1:0] pos_inc;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      inc_ext;
	logic [CMP_W-1:0]      limit_ext;

	assign advance   = head_valid && (!out_valid_q || !out_stall);
	assign is_last   = k_q == head_seq.last_idx;
	assign pop       = advance && is_last;
	assign pos_inc   = (pos_q == {COUNT_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
	assign pos_ext   = CMP_W'(pos_q);
	assign inc_ext   = CMP_W'(pos_inc);
	assign limit_ext = CMP_W'(out_limit);

	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q <= head_seq.chars[k_q];
			stored_q   <= pos_ext < limit_ext;
			run_last_q <= is_last;
			total_q    <= inc_ext[bee_pkg::LENGTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				k_q         <= is_last ? 2'd0 : k_q + 2'd1;
				pos_q       <= (is_last && head_seq.str_end) ? '0 : pos_inc;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign stored       = stored_q;
	assign run_last     = run_last_q;
	assign total_length = total_q;

`ifndef SYNTHESIS
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && run_last)
		else $error("item retired without a last character");
	a_escape_leads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && k_q == 2'd0 && head_seq.last_idx != 2'd0
		|=> out_char == bee_pkg::CH_BACKSLASH)
		else $error("escape sequence without leading backslash");
	a_no_mid_index: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> k_q <= head_seq.last_idx)
		else $error("character index past end of sequence");
`endif

endmodule

[hw/rtl/byte_escape_encoder.sv]
// top level of the byte escape encoder: configuration registers and datapath
//
// byte_escape_encoder escapes a byte stream one source item at a time. each
// item yields one to four result items, one output character each: the byte
// itself, a two-character escape (\n \r \t \v \f, \\ \a \e, \0), or a
// four-character octal (\ooo) or hex (\xhh, lowercase) escape, chosen by the
// escape_flags register and optionally restricted to the 256-bit character
// set. the front end classifies a byte in the cycle it is accepted and drops
// the finished sequence into a two-entry queue; the back end emits one
// character per cycle through its output register while out_stall is low,
// so a byte costs one, two or four output characters. each character carries
// stored (its position was below out_limit), run_last and the running
// length, which saturates at 2^COUNT_BITS-1 and returns to zero after a byte
// marked string_end. configuration writes take effect at once and are meant
// for when the block is idle.
module byte_escape_encoder #(
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [bee_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bee_pkg::CFG_DATA_W-1:0]    cfg_data,
	// source items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_byte,
	input  logic                              string_end,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_char,
	output logic                              stored,
	output logic                              run_last,
	output logic [bee_pkg::LENGTH_W-1:0]      total_length
);

	// configuration state
	logic [bee_pkg::FLAGS_W-1:0] escape_flags_q;
	logic [bee_pkg::LIMIT_W-1:0] out_limit_q;
	logic                        set_enable_q;
	logic [63:0]                 set_mask_a_q;
	logic [63:0]                 set_mask_b_q;
	logic [63:0]                 set_mask_c_q;
	logic [63:0]                 set_mask_d_q;

	// front to queue to back
	bee_pkg::seq_t front_seq;
	bee_pkg::seq_t head_seq;
	logic          push;
	logic          q_full;
	logic          pop;
	logic          head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_flags_q <= '0;
			out_limit_q    <= '0;
			set_enable_q   <= 1'b0;
			set_mask_a_q   <= '0;
			set_mask_b_q   <= '0;
			set_mask_c_q   <= '0;
			set_mask_d_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				bee_pkg::CFG_ESCAPE_FLAGS: escape_flags_q <= cfg_data[bee_pkg::FLAGS_W-1:0];
				bee_pkg::CFG_OUT_LIMIT:    out_limit_q    <= cfg_data[bee_pkg::LIMIT_W-1:0];
				bee_pkg::CFG_SET_ENABLE:   set_enable_q   <= cfg_data[0];
				bee_pkg::CFG_SET_MASK_A:   set_mask_a_q   <= cfg_data;
				bee_pkg::CFG_SET_MASK_B:   set_mask_b_q   <= cfg_data;
				bee_pkg::CFG_SET_MASK_C:   set_mask_c_q   <= cfg_data;
				bee_pkg::CFG_SET_MASK_D:   set_mask_d_q   <= cfg_data;
				default: ;  // unused index, write ignored
			endcase
		end
	end

	// a source item is taken whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	bee_front u_front (
		.in_byte      (in_byte),
		.string_end   (string_end),
		.escape_flags (escape_flags_q),
		.set_enable   (set_enable_q),
		.set_mask     ({set_mask_d_q, set_mask_c_q, set_mask_b_q, set_mask_a_q}),
		.seq          (front_seq)
	);

	bee_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_seq  (front_seq),
		.full      (q_full),
		.pop       (pop),
		.not_empty (head_valid),
		.head_seq  (head_seq)
	);

	// back end retires a queue entry with its last character
	bee_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_seq     (head_seq),
		.pop          (pop),
		.out_limit    (out_limit_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.stored       (stored),
		.run_last     (run_last),
		.total_length (total_length)
	);

endmodule

[tb/sv/byte_escape_encoder_tb.sv]
// self-checking testbench for the byte escape encoder: directed and random strings
module byte_escape_encoder_tb;

	// length counter at the width of the total_length port
	localparam int COUNT_W = 32;
	localparam logic [63:0] POS_MAX = (64'd1 << COUNT_W) - 64'd1;

	// run control
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	// escape_flags values built from the package bit positions
	localparam logic [5:0] F_SPACE   = 6'(1 << bee_pkg::FLAG_SPACE);
	localparam logic [5:0] F_SPECIAL = 6'(1 << bee_pkg::FLAG_SPECIAL);
	localparam logic [5:0] F_NULL    = 6'(1 << bee_pkg::FLAG_NULL);
	localparam logic [5:0] F_OCTAL   = 6'(1 << bee_pkg::FLAG_OCTAL);
	localparam logic [5:0] F_SKIP    = 6'(1 << bee_pkg::FLAG_SKIP);
	localparam logic [5:0] F_HEX     = 6'(1 << bee_pkg::FLAG_HEX);
	localparam logic [5:0] F_ALL     = 6'h3F;

	// one source item waiting to be offered
	typedef struct {
		logic [7:0] data;
		logic       last;
	} src_item_t;

	// one predicted output character
	typedef struct {
		logic [7:0]                   chr;
		logic                         stored;
		logic                         run_last;
		logic [bee_pkg::LENGTH_W-1:0] length;
	} escaped_char_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [bee_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [bee_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [7:0]                      in_byte = 8'h00;
	logic                            string_end = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [7:0]                      out_char;
	logic                            stored;
	logic                            run_last;
	logic [bee_pkg::LENGTH_W-1:0]    total_length;

	byte_escape_encoder #(
		.COUNT_BITS(COUNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.string_end(string_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.stored(stored),
		.run_last(run_last),
		.total_length(total_length)
	);

	// predictor copy of the registers and the output position
	logic [5:0]  flags_cur = '0;
	logic [31:0] limit_cur = '0;
	logic        set_en_cur = 1'b0;
	logic [63:0] set_mask_cur [4] = '{default: '0};
	logic [63:0] position_cur = '0;

	src_item_t     pending_bytes [$];
	escaped_char_t expected_chars [$];

	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned checked_count = 0;
	int unsigned phase_count = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// idling rates in percent, set per phase
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// long receiver hold-off, counted in its own process
	logic        hold_request = 1'b0;
	logic        hold_taken = 1'b0;
	int unsigned hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? 8'("0" + v) : 8'("a" + (v - 4'd10));
	endfunction

	// works out the escaped characters of one accepted byte and queues them
	task automatic predict_escape(input logic [7:0] c, input logic str_end);
		logic [7:0]    seq [4];
		int            n;
		logic [7:0]    ws_code;
		logic [7:0]    sp_code;
		logic          printable;
		logic          member;
		escaped_char_t r;
		seq[0] = c;
		seq[1] = 8'h00;
		seq[2] = 8'h00;
		seq[3] = 8'h00;
		n = 1;
		printable = (c >= 8'h20 && c <= 8'h7E) || c >= 8'hA0;
		// byte zero counts as a member whatever the mask says
		member = (c == 8'h00) || set_mask_cur[c[7:6]][c[5:0]];
		case (c)
			8'h0A: ws_code = "n";
			8'h0D: ws_code = "r";
			8'h09: ws_code = "t";
			8'h0B: ws_code = "v";
			8'h0C: ws_code = "f";
			default: ws_code = 8'h00;
		endcase
		case (c)
			bee_pkg::CH_BACKSLASH: sp_code = bee_pkg::CH_BACKSLASH;
			8'h07: sp_code = "a";
			8'h1B: sp_code = "e";
			default: sp_code = 8'h00;
		endcase
		if (!(flags_cur[bee_pkg::FLAG_SKIP] && printable) && !(set_en_cur && !member)) begin
			if (flags_cur[bee_pkg::FLAG_SPACE] && ws_code != 8'h00) begin
				seq[0] = bee_pkg::CH_BACKSLASH;
				seq[1] = ws_code;
				n = 2;
			end else if (flags_cur[bee_pkg::FLAG_SPECIAL] && sp_code != 8'h00) begin
				seq[0] = bee_pkg::CH_BACKSLASH;
				seq[1] = sp_code;
				n = 2;
			end else if (flags_cur[bee_pkg::FLAG_NULL] && c == 8'h00) begin
				seq[0] = bee_pkg::CH_BACKSLASH;
				seq[1] = "0";
				n = 2;
			end else if (flags_cur[bee_pkg::FLAG_OCTAL]) begin
				seq[0] = bee_pkg::CH_BACKSLASH;
				seq[1] = 8'("0" + c[7:6]);
				seq[2] = 8'("0" + c[5:3]);
				seq[3] = 8'("0" + c[2:0]);
				n = 4;
			end else if (flags_cur[bee_pkg::FLAG_HEX]) begin
				seq[0] = bee_pkg::CH_BACKSLASH;
				seq[1] = "x";
				seq[2] = hex_char(c[7:4]);
				seq[3] = hex_char(c[3:0]);
				n = 4;
			end
		end
		for (int k = 0; k < n; k++) begin
			r.chr = seq[k];
			r.stored = (position_cur < {32'd0, limit_cur});
			r.run_last = (k == n - 1);
			// position sticks at its maximum once reached
			if (position_cur < POS_MAX)
				position_cur = position_cur + 64'd1;
			r.length = position_cur[bee_pkg::LENGTH_W-1:0];
			expected_chars.push_back(r);
		end
		if (str_end)
			position_cur = '0;
	endtask

	// sender: offers queued items, holds a stalled item steady
	always @(posedge clk) begin : source_driver
		src_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_escape(in_byte, string_end);
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.data;
					string_end <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off: one long stretch while the sender keeps offering
	always @(posedge clk) begin : hold_off
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_taken && pending_bytes.size() != 0) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end
	end

	// receiver: checks every accepted character against the oldest prediction
	always @(posedge clk) begin : result_monitor
		escaped_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected result item: out_char %h", out_char);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.chr) begin
					$error("out_char: expected %h, got %h", want.chr, out_char);
					error_count++;
				end
				if (stored !== want.stored) begin
					$error("stored: expected %b, got %b", want.stored, stored);
					error_count++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, run_last);
					error_count++;
				end
				if (total_length !== want.length) begin
					$error("total_length: expected %0d, got %0d", want.length, total_length);
					error_count++;
				end
				checked_count++;
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(input logic [7:0] data, input logic last);
		src_item_t it;
		it.data = data;
		it.last = last;
		pending_bytes.push_back(it);
		queued_count++;
	endtask

	// one register write; the block is idle whenever this is called
	task automatic write_reg(input logic [bee_pkg::CFG_INDEX_W-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			bee_pkg::CFG_ESCAPE_FLAGS: flags_cur = val[5:0];
			bee_pkg::CFG_OUT_LIMIT: limit_cur = val[31:0];
			bee_pkg::CFG_SET_ENABLE: set_en_cur = val[0];
			bee_pkg::CFG_SET_MASK_A: set_mask_cur[0] = val;
			bee_pkg::CFG_SET_MASK_B: set_mask_cur[1] = val;
			bee_pkg::CFG_SET_MASK_C: set_mask_cur[2] = val;
			bee_pkg::CFG_SET_MASK_D: set_mask_cur[3] = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [5:0] flags, input logic [31:0] limit,
			input logic set_en, input logic [63:0] ma, input logic [63:0] mb,
			input logic [63:0] mc, input logic [63:0] md);
		write_reg(bee_pkg::CFG_ESCAPE_FLAGS, {58'd0, flags});
		write_reg(bee_pkg::CFG_OUT_LIMIT, {32'd0, limit});
		write_reg(bee_pkg::CFG_SET_ENABLE, {63'd0, set_en});
		write_reg(bee_pkg::CFG_SET_MASK_A, ma);
		write_reg(bee_pkg::CFG_SET_MASK_B, mb);
		write_reg(bee_pkg::CFG_SET_MASK_C, mc);
		write_reg(bee_pkg::CFG_SET_MASK_D, md);
		phase_count++;
	endtask

	// waits until every queued item is in and every character is out
	task automatic drain();
		while (accepted_count != queued_count || expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// byte mix weighted towards the escape classes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(11))
			0: return 8'h0A;
			1: return 8'(8'h09 + $urandom_range(4));
			2: return bee_pkg::CH_BACKSLASH;
			3: return ($urandom_range(1) != 0) ? 8'h07 : 8'h1B;
			4: return 8'h00;
			5, 6: return 8'($urandom_range(8'h7E, 8'h20));
			7: return 8'($urandom_range(8'hFF, 8'hA0));
			8: return 8'($urandom_range(8'hA0, 8'h7F));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// strings of random length closed by string_end, with the odd stray flag
	task automatic queue_strings(input int unsigned count, input int unsigned max_len);
		int unsigned left;
		int unsigned len;
		logic        last;
		left = count;
		while (left > 0) begin
			len = $urandom_range(max_len, 1);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++) begin
				last = (i == len - 1);
				if ($urandom_range(9) == 0)
					last = ~last;
				push_item(pick_byte(), last);
			end
			left -= len;
		end
	endtask

	initial begin : sequencer
		int unsigned m;
		logic [5:0]  flags_v;
		logic [31:0] limit_v;
		logic [63:0] mask_v [4];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: everything passes through, nothing stored
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item("A", 1'b1);
		drain();

		// whitespace, special, null and octal classes with a short buffer
		configure(F_SPACE | F_SPECIAL | F_NULL | F_OCTAL, 32'd5, 1'b0,
			64'd0, 64'd0, 64'd0, 64'd0);
		push_item(8'h0A, 1'b0);
		push_item(8'h0D, 1'b0);
		push_item(8'h09, 1'b0);
		push_item(8'h0B, 1'b0);
		push_item(8'h0C, 1'b1);
		push_item(bee_pkg::CH_BACKSLASH, 1'b0);
		push_item(8'h07, 1'b0);
		push_item(8'h1B, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b1);
		drain();

		// hex with printable bytes skipped, buffer at its largest
		configure(F_HEX | F_SKIP, 32'hFFFF_FFFF, 1'b0,
			64'd0, 64'd0, 64'd0, 64'd0);
		push_item(8'h00, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h9F, 1'b0);
		push_item("A", 1'b0);
		push_item(8'hA0, 1'b0);
		push_item(8'hFF, 1'b1);
		drain();

		// character set on: byte zero is a member though its mask bit is clear
		configure(F_ALL, 32'd0, 1'b1, 64'd0,
			64'd1 << (bee_pkg::CH_BACKSLASH - 8'd64), 64'd0,
			64'h8000_0000_0000_0000);
		push_item(8'h00, 1'b0);
		push_item(8'h0A, 1'b0);
		push_item(bee_pkg::CH_BACKSLASH, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item("A", 1'b1);
		drain();

		// one long string in octal that runs past the buffer limit,
		// then a short one to see the length start again from zero
		configure(F_OCTAL, 32'd256, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
		for (int i = 0; i < 70; i++)
			push_item(8'($urandom_range(255)), i == 69);
		for (int i = 0; i < 3; i++)
			push_item(pick_byte(), i == 2);
		drain();

		// random phases, each with its own settings and idling pattern
		for (int p = 0; p < 7; p++) begin
			m = p % 4;
			case (m)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 66;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 66;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			flags_v = (p == 0) ? F_ALL : (p == 1) ? 6'd0 : 6'($urandom_range(63));
			case (m)
				0: limit_v = 32'hFFFF_FFFF;
				1: limit_v = 32'd0;
				2: limit_v = 32'($urandom_range(60));
				default: limit_v = 32'd255;
			endcase
			for (int j = 0; j < 4; j++) begin
				if (p == 2)
					mask_v[j] = '1;
				else if (p == 5)
					mask_v[j] = '0;
				else
					mask_v[j] = {$urandom, $urandom};
			end
			configure(flags_v, limit_v, 1'(p % 2), mask_v[0], mask_v[1], mask_v[2],
				mask_v[3]);
			// the block fills up behind a long receiver hold-off here
			if (p == 4)
				hold_request = 1'b1;
			queue_strings(24, 12);
			drain();
		end

		if (expected_chars.size() != 0) begin
			$error("%0d predicted characters never arrived", expected_chars.size());
			error_count++;
		end
		$display("%0d source items in %0d register settings, %0d characters compared",
			accepted_count, phase_count, checked_count);
		$display("covered all escape classes, set filtering, buffer limits, string restarts"
			, " and sender/receiver idling with one long hold-off");
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/bee_pkg.sv
hw/rtl/bee_front.sv
hw/rtl/bee_queue.sv
hw/rtl/bee_back.sv
hw/rtl/byte_escape_encoder.sv
tb/sv/byte_escape_encoder_tb.sv
